FILE: hw/rtl/dths_pkg.sv
// ----------------------------------------------------------------------------
// dths_pkg: shared constants, types and functions for the pair search block
// Sizes, action codes and the piecewise linear tanh table.
// ----------------------------------------------------------------------------
package dths_pkg;

  localparam int MaxPoints = 128;
  localparam int MaxWidth = 5;
  localparam int WCols = MaxWidth + 1;
  localparam int PtAw = $clog2(MaxPoints * MaxWidth);
  localparam int WtAw = $clog2(MaxWidth * WCols);
  localparam int SimAw = $clog2(MaxPoints * MaxPoints);
  localparam int IdxW = 7;
  localparam int PcW = $clog2(MaxPoints + 1);
  localparam int KW = $clog2(MaxWidth + 2);

  localparam logic [1:0] ACT_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_POINT  = 2'd1;
  localparam logic [1:0] ACT_SIM    = 2'd2;
  localparam logic [1:0] ACT_RUN    = 2'd3;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_IN_W  = 2'd1;
  localparam logic [1:0] REG_OUT_W = 2'd2;

  typedef struct packed {
    logic [IdxW-1:0] far_first;
    logic [IdxW-1:0] far_second;
    logic [15:0]     far_distance;
    logic [IdxW-1:0] near_first;
    logic [IdxW-1:0] near_second;
    logic [15:0]     near_distance;
  } result_t;

  typedef struct packed {
    logic [PcW-1:0] n;
    logic [KW-1:0]  iw;
    logic [KW-1:0]  ow;
  } cfg_t;

  function automatic logic [15:0] tanh_tab(input logic [4:0] s);
    logic [15:0] r;
    case (s)
      5'd0: r = 16'd0;      5'd1: r = 16'd8025;   5'd2: r = 16'd15143;
      5'd3: r = 16'd20813;  5'd4: r = 16'd24956;  5'd5: r = 16'd27797;
      5'd6: r = 16'd29660;  5'd7: r = 16'd30847;  5'd8: r = 16'd31589;
      5'd9: r = 16'd32048;  5'd10: r = 16'd32329; 5'd11: r = 16'd32501;
      5'd12: r = 16'd32606; 5'd13: r = 16'd32670; 5'd14: r = 16'd32708;
      5'd15: r = 16'd32732; 5'd16: r = 16'd32746;
      default: r = 16'd32767;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/dense_tanh_hard_pair_search.sv
// ----------------------------------------------------------------------------
// dense_tanh_hard_pair_search: hard pair mining through one dense tanh layer
// Stream in load and run beats, APB registers, one result beat per run.
// ----------------------------------------------------------------------------
// Timing: a run evaluates every neuron for every point, then scans every
// pair, paced by the single output memory read port and the bit-serial
// square root. Throughput: one beat at a time; loads at one per cycle
// while the core is idle and no result waits.
// Reset: synchronous, active high; clears control and pairs, registers
// go to defaults. Stores are undefined until written, no clearing pass.
module dense_tanh_hard_pair_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tuser: action[1:0]
  input  logic [1:0]  s_tuser,
  // tdata: index_a[6:0], index_b[13:7], value[29:14], same_class[30]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: far_first, far_second, far_distance, near_first, near_second,
  // near_distance, from the lowest bit up
  output logic [63:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [7:0] point_count;
  logic [2:0] in_width, out_width;
  dths_pkg::cfg_t cfg;
  dths_pkg::result_t res;
  logic idle, done, acc_in, load;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 8'd100; in_width <= 3'd2; out_width <= 3'd5;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        dths_pkg::REG_COUNT: point_count <= pwdata[7:0];
        dths_pkg::REG_IN_W:  in_width <= pwdata[2:0];
        dths_pkg::REG_OUT_W: out_width <= pwdata[2:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      dths_pkg::REG_COUNT: prdata = {24'd0, point_count};
      dths_pkg::REG_IN_W:  prdata = {29'd0, in_width};
      dths_pkg::REG_OUT_W: prdata = {29'd0, out_width};
      default: prdata = '0;
    endcase
  end

  // Clamp the configuration to the store sizes.
  assign cfg.n  = (point_count > 8'(dths_pkg::MaxPoints)) ? 8'(dths_pkg::MaxPoints)
                                                          : point_count;
  assign cfg.iw = (in_width > 3'(dths_pkg::MaxWidth)) ? 3'(dths_pkg::MaxWidth) : in_width;
  assign cfg.ow = (out_width > 3'(dths_pkg::MaxWidth)) ? 3'(dths_pkg::MaxWidth) : out_width;

  // Input is taken only when the core is idle and no result waits.
  assign s_tready = idle && !m_tvalid;
  assign acc_in = s_tvalid && s_tready;
  assign load = acc_in && s_tuser != dths_pkg::ACT_RUN;

  dths_core u_core (
    .clk, .rst, .cfg,
    .start(acc_in && s_tuser == dths_pkg::ACT_RUN),
    .load, .action(s_tuser), .index_a(s_tdata[6:0]), .index_b(s_tdata[13:7]),
    .value(s_tdata[29:14]), .same_class(s_tdata[30]),
    .idle, .done, .res
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {4'd0, res.near_distance, res.near_second, res.near_first,
                   res.far_distance, res.far_second, res.far_first};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    !idle |-> !s_tready) else $error("accepted while busy");
  a_done_sets_valid: assert property (@(posedge clk) disable iff (rst)
    done |=> m_tvalid) else $error("result lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
endmodule

FILE: hw/rtl/dths_ram.sv
// ----------------------------------------------------------------------------
// dths_ram: generic single-port-write, single-read RAM
// Synchronous write and registered read.
// ----------------------------------------------------------------------------
module dths_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/dths_isqrt.sv
// ----------------------------------------------------------------------------
// dths_isqrt: iterative floor square root, one result bit per cycle
// Takes a 29-bit radicand and returns a 15-bit root after 15 steps.
// ----------------------------------------------------------------------------
module dths_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [28:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  logic [29:0] rem;
  logic [29:0] res;
  logic [29:0] bitv;
  logic        busy;
  logic [29:0] trial;

  assign trial = res + bitv;
  assign root = res[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= {1'b0, radicand};
        res  <= '0;
        bitv <= 30'h1 << 28;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 30'h1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/dths_core.sv
// ----------------------------------------------------------------------------
// dths_core: layer evaluation and pair scan sequencer
// Loads the stores, runs the dense tanh layer and walks all pairs.
// ----------------------------------------------------------------------------
module dths_core (
  input  logic                   clk,
  input  logic                   rst,
  input  dths_pkg::cfg_t         cfg,
  input  logic                   start,
  input  logic                   load,
  input  logic [1:0]             action,
  input  logic [6:0]             index_a,
  input  logic [6:0]             index_b,
  input  logic signed [15:0]     value,
  input  logic                   same_class,
  output logic                   idle,
  output logic                   done,
  output dths_pkg::result_t      res
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LRD   = 4'd1;
  localparam logic [3:0] S_LMAC  = 4'd2;
  localparam logic [3:0] S_LADD  = 4'd3;
  localparam logic [3:0] S_TANH  = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PMAC  = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [6:0] pi, pj;
  logic [dths_pkg::KW-1:0] nj, kk;
  logic       phase_b;
  logic signed [39:0] acc;
  logic signed [31:0] prod;
  logic signed [31:0] mac_prod;
  logic       mac_v;
  logic       far_found, near_found;
  logic [15:0] far_best, near_best;
  logic [31:0] sq;
  logic [34:0] dsum;
  logic signed [15:0] oa;
  logic       sq_v;

  // stores
  logic pt_we, wt_we, sim_we, out_we;
  logic [dths_pkg::PtAw-1:0] pt_wa, pt_ra, out_wa, out_ra;
  logic [dths_pkg::WtAw-1:0] wt_wa, wt_ra;
  logic [dths_pkg::SimAw-1:0] sim_wa, sim_ra;
  logic [15:0] pt_rd, wt_rd, out_rd, out_wd;
  logic [0:0] sim_rd;

  dths_ram #(.Width(16), .Depth(dths_pkg::MaxPoints * dths_pkg::MaxWidth)) u_pt (
    .clk, .we(pt_we), .waddr(pt_wa), .wdata(value), .raddr(pt_ra), .rdata(pt_rd));
  dths_ram #(.Width(16), .Depth(dths_pkg::MaxWidth * dths_pkg::WCols)) u_wt (
    .clk, .we(wt_we), .waddr(wt_wa), .wdata(value), .raddr(wt_ra), .rdata(wt_rd));
  dths_ram #(.Width(1), .Depth(dths_pkg::MaxPoints * dths_pkg::MaxPoints)) u_sim (
    .clk, .we(sim_we), .waddr(sim_wa), .wdata(same_class), .raddr(sim_ra),
    .rdata(sim_rd));
  dths_ram #(.Width(16), .Depth(dths_pkg::MaxPoints * dths_pkg::MaxWidth)) u_out (
    .clk, .we(out_we), .waddr(out_wa), .wdata(out_wd), .raddr(out_ra),
    .rdata(out_rd));

  assign pt_we  = load && action == dths_pkg::ACT_POINT && index_b < 7'(dths_pkg::MaxWidth);
  assign wt_we  = load && action == dths_pkg::ACT_WEIGHT &&
                  index_a < 7'(dths_pkg::MaxWidth) && index_b <= 7'(dths_pkg::MaxWidth);
  assign sim_we = load && action == dths_pkg::ACT_SIM;
  assign pt_wa  = dths_pkg::PtAw'(index_a * dths_pkg::MaxWidth + index_b);
  assign wt_wa  = dths_pkg::WtAw'(index_a * dths_pkg::WCols + index_b);
  assign sim_wa = {index_a, index_b};

  // point i, neuron nj, input kk (kk == iw selects bias)
  assign pt_ra  = dths_pkg::PtAw'(pi * dths_pkg::MaxWidth + kk);
  assign wt_ra  = dths_pkg::WtAw'(nj * dths_pkg::WCols + kk);
  assign sim_ra = {pi, pj};
  assign out_ra = dths_pkg::PtAw'((phase_b ? pj : pi) * dths_pkg::MaxWidth + kk);
  assign out_wa = dths_pkg::PtAw'(pi * dths_pkg::MaxWidth + nj);

  assign mac_prod = signed'(pt_rd) * signed'(wt_rd);

  // tanh of the accumulator
  logic        tneg;
  logic [39:0] tmag;
  logic [17:0] tseg;
  logic [21:0] tfrac;
  logic [15:0] tlo, tdiff, ty;
  logic [37:0] tprod;
  always_comb begin
    tneg  = acc[39];
    tmag  = tneg ? 40'(-acc) : 40'(acc);
    tseg  = tmag[39:22];
    tfrac = tmag[21:0];
    tlo   = dths_pkg::tanh_tab(tseg[4:0]);
    tdiff = dths_pkg::tanh_tab(5'(tseg[4:0] + 5'd1)) - tlo;
    tprod = 38'(tdiff) * 38'(tfrac);
    ty    = (tseg >= 18'd16) ? 16'd32767 : 16'(tlo + tprod[37:22]);
    out_wd = tneg ? 16'(-ty) : ty;
  end

  assign out_we = state == S_TANH;

  logic sq_start, sq_done;
  logic [15:0] sq_root;
  dths_isqrt u_sqrt (.clk, .rst, .start(sq_start), .radicand(dsum[34:6]),
                     .done(sq_done), .root(sq_root));
  assign sq_start = state == S_PMAC && !mac_v && !sq_v && kk == cfg.ow && !phase_b;

  assign idle = state == S_IDLE;
  assign done = state == S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= '0;
      mac_v <= 1'b0;
      sq_v  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pi <= '0; nj <= '0; kk <= '0; acc <= '0;
            far_found <= 1'b0; near_found <= 1'b0;
            state <= (cfg.n == '0) ? S_DONE : S_LRD;
          end
        end
        S_LRD: begin
          state <= S_LMAC;
        end
        S_LMAC: begin
          // pt_rd/wt_rd hold data for kk
          if (kk == cfg.iw) begin
            prod  <= -32'sd4096 * 32'(signed'(wt_rd));
            state <= S_LADD;
          end else begin
            acc <= acc + 40'(mac_prod);
            kk  <= kk + 1'b1;
            state <= S_LRD;
          end
        end
        S_LADD: begin
          acc <= acc + 40'(prod);
          state <= S_TANH;
        end
        S_TANH: begin
          acc <= '0; kk <= '0;
          if (nj + 1'b1 < cfg.ow) begin
            nj <= nj + 1'b1; state <= S_LRD;
          end else if (8'(pi) + 8'd1 < 8'(cfg.n)) begin
            nj <= '0; pi <= pi + 1'b1; state <= S_LRD;
          end else if (cfg.n < 8'd2) begin
            state <= S_DONE;
          end else begin
            pi <= '0; pj <= 7'd1; phase_b <= 1'b0; dsum <= '0; state <= S_PRD;
          end
        end
        S_PRD: begin
          state <= S_PMAC;
        end
        S_PMAC: begin
          // alternate: read out[i][k], then out[j][k]
          if (sq_v) begin
            dsum <= dsum + 35'(sq); sq_v <= 1'b0;
          end else if (mac_v) begin
            sq <= 32'(($signed({oa[15], oa}) - $signed({out_rd[15], out_rd})) *
                      ($signed({oa[15], oa}) - $signed({out_rd[15], out_rd})));
            mac_v <= 1'b0; sq_v <= 1'b1;
            kk <= kk + 1'b1; phase_b <= 1'b0; state <= S_PRD;
          end else if (kk == cfg.ow) begin
            state <= S_SQRT;
          end else if (!phase_b) begin
            oa <= out_rd; phase_b <= 1'b1; state <= S_PRD; mac_v <= 1'b1;
          end
        end
        S_SQRT: begin
          if (sq_done) state <= S_CMP;
        end
        S_CMP: begin
          if (sim_rd[0]) begin
            if (!far_found || sq_root > far_best) begin
              far_found <= 1'b1; far_best <= sq_root;
              res.far_first <= pi; res.far_second <= pj; res.far_distance <= sq_root;
            end
          end else if (!near_found || sq_root < near_best) begin
            near_found <= 1'b1; near_best <= sq_root;
            res.near_first <= pi; res.near_second <= pj; res.near_distance <= sq_root;
          end
          dsum <= '0; kk <= '0;
          if (8'(pj) + 8'd1 < 8'(cfg.n)) begin
            pj <= pj + 1'b1; state <= S_PRD;
          end else if (8'(pi) + 8'd2 < 8'(cfg.n)) begin
            pi <= pi + 1'b1; pj <= pi + 7'd2; state <= S_PRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/sv/dense_tanh_hard_pair_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dense_tanh_hard_pair_search_checker: result predictor and scoreboard
// Watches the register port and both streams, recomputes each run from its
// own copy of the stores and compares every result beat field by field.
// ----------------------------------------------------------------------------
module dense_tanh_hard_pair_search_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [1:0]  s_tuser,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  localparam int Curve [17] = '{0, 8025, 15143, 20813, 24956, 27797, 29660, 30847,
                                31589, 32048, 32329, 32501, 32606, 32670, 32708,
                                32732, 32746};

  logic [7:0] count_reg;
  logic [2:0] inw_reg, outw_reg;
  logic signed [15:0] coords  [dths_pkg::MaxPoints][dths_pkg::MaxWidth];
  logic signed [15:0] weights [dths_pkg::MaxWidth][dths_pkg::WCols];
  logic               sim_bit [dths_pkg::MaxPoints][dths_pkg::MaxPoints];
  logic signed [15:0] layer_out [dths_pkg::MaxPoints][dths_pkg::MaxWidth];
  logic [6:0]  far_i, far_j, near_i, near_j;
  logic [15:0] far_d, near_d;
  dths_pkg::result_t expected_pairs [$];

  assign pending = expected_pairs.size();

  function automatic logic signed [15:0] squash_q15(longint x);
    longint mag, seg;
    int y;
    mag = (x < 0) ? -x : x;
    seg = mag >>> 22;
    if (seg >= 16) begin
      y = 32767;
    end else begin
      y = Curve[seg] + int'(((Curve[seg+1] - Curve[seg]) * (mag & 64'h3F_FFFF)) >>> 22);
    end
    return (x < 0) ? 16'(-y) : 16'(y);
  endfunction

  function automatic logic [15:0] floor_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[15:0];
  endfunction

  // One run: dense layer over every point, then the strict pair scan.
  task automatic run_search();
    int n, iw, ow;
    longint acc, d;
    longint unsigned sq;
    logic [15:0] pair_dist, far_best, near_best;
    bit far_hit, near_hit;
    dths_pkg::result_t r;
    n  = (count_reg > dths_pkg::MaxPoints) ? dths_pkg::MaxPoints : count_reg;
    iw = (inw_reg > dths_pkg::MaxWidth) ? dths_pkg::MaxWidth : inw_reg;
    ow = (outw_reg > dths_pkg::MaxWidth) ? dths_pkg::MaxWidth : outw_reg;
    far_hit = 0;
    near_hit = 0;
    far_best = 0;
    near_best = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < ow; j++) begin
        acc = 0;
        for (int k = 0; k < iw; k++) acc += longint'(coords[i][k]) * longint'(weights[j][k]);
        acc -= 4096 * longint'(weights[j][iw]);
        layer_out[i][j] = squash_q15(acc);
      end
    for (int i = 0; i + 1 < n; i++)
      for (int j = i + 1; j < n; j++) begin
        sq = 0;
        for (int k = 0; k < ow; k++) begin
          d = longint'(layer_out[i][k]) - longint'(layer_out[j][k]);
          sq += d * d;
        end
        pair_dist = floor_root(sq >> 6);
        if (sim_bit[i][j]) begin
          if (!far_hit || pair_dist > far_best) begin
            far_hit = 1; far_best = pair_dist;
            far_i = 7'(i); far_j = 7'(j); far_d = pair_dist;
          end
        end else if (!near_hit || pair_dist < near_best) begin
          near_hit = 1; near_best = pair_dist;
          near_i = 7'(i); near_j = 7'(j); near_d = pair_dist;
        end
      end
    r.far_first = far_i;  r.far_second = far_j;  r.far_distance = far_d;
    r.near_first = near_i; r.near_second = near_j; r.near_distance = near_d;
    expected_pairs.push_back(r);
  endtask

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < dths_pkg::MaxPoints; i++)
      for (int j = 0; j < dths_pkg::MaxPoints; j++) sim_bit[i][j] = 0;
  end

  always @(posedge clk) begin
    logic [1:0] act;
    logic [6:0] ia, ib;
    dths_pkg::result_t r;
    if (rst) begin
      count_reg <= 8'd100; inw_reg <= 3'd2; outw_reg <= 3'd5;
      far_i <= 0; far_j <= 0; far_d <= 0;
      near_i <= 0; near_j <= 0; near_d <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          dths_pkg::REG_COUNT: count_reg <= pwdata[7:0];
          dths_pkg::REG_IN_W:  inw_reg   <= pwdata[2:0];
          dths_pkg::REG_OUT_W: outw_reg  <= pwdata[2:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        act = s_tuser;
        ia  = s_tdata[6:0];
        ib  = s_tdata[13:7];
        case (act)
          dths_pkg::ACT_WEIGHT:
            if (ia < dths_pkg::MaxWidth && ib <= dths_pkg::MaxWidth)
              weights[ia][ib] = s_tdata[29:14];
          dths_pkg::ACT_POINT:
            if (ib < dths_pkg::MaxWidth) coords[ia][ib] = s_tdata[29:14];
          dths_pkg::ACT_SIM: sim_bit[ia][ib] = s_tdata[30];
          dths_pkg::ACT_RUN: run_search();
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_pairs.size() == 0) begin
          $error("result beat with no run outstanding: %h", m_tdata);
          fail_count++;
        end else begin
          r = expected_pairs.pop_front();
          compare_field("far_first",     r.far_first,     m_tdata[6:0]);
          compare_field("far_second",    r.far_second,    m_tdata[13:7]);
          compare_field("far_distance",  r.far_distance,  m_tdata[29:14]);
          compare_field("near_first",    r.near_first,    m_tdata[36:30]);
          compare_field("near_second",   r.near_second,   m_tdata[43:37]);
          compare_field("near_distance", r.near_distance, m_tdata[59:44]);
        end
      end
    end
  end

endmodule

FILE: tb/sv/dense_tanh_hard_pair_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dense_tanh_hard_pair_search_test: top of the pair search testbench
// Preloads the stores a run reads, runs directed corner runs, then random load
// and run beats across several register settings with random stalls.
// ----------------------------------------------------------------------------
module dense_tanh_hard_pair_search_test;

  // Runs never use more points than this, so only this region is preloaded.
  localparam int PreN = 12;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // tuser: action[1:0]
  logic [1:0]  s_tuser;
  // tdata: index_a[6:0], index_b[13:7], value[29:14], same_class[30]
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // tdata: far_first, far_second, far_distance, near_first, near_second,
  // near_distance, from the lowest bit up
  logic [63:0] m_tdata;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  int fail_count;
  int runs_pending;
  // quiet turns off idling on both streams for the last stretch of the run.
  bit quiet;
  int idle_odds;
  int stall_left;

  dense_tanh_hard_pair_search u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dense_tanh_hard_pair_search_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending(runs_pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Generous ceiling: the whole test with all stalls stays well under this
  // limit; reaching it reports a failure.
  initial begin
    #80_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: random bursts of back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send(logic [1:0] act, int a, int b, logic [15:0] v, logic sc);
    if (!quiet && idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, sc, v, 7'(b), 7'(a)};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Let every run finish; loads cause no result, so a short tail covers them.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait (runs_pending == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_shape(int n, int iw, int ow);
    settle();
    reg_write(dths_pkg::REG_COUNT, n);
    reg_write(dths_pkg::REG_IN_W, iw);
    reg_write(dths_pkg::REG_OUT_W, ow);
  endtask

  initial begin
    int n;
    int pick;
    quiet = 0;
    idle_odds = 20;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every store entry a run can read, so no run sees unwritten data.
    for (int r = 0; r < dths_pkg::MaxWidth; r++)
      for (int c = 0; c < dths_pkg::WCols; c++)
        send(dths_pkg::ACT_WEIGHT, r, c, 16'($urandom), 1'b0);
    for (int p = 0; p < PreN; p++)
      for (int c = 0; c < dths_pkg::MaxWidth; c++)
        send(dths_pkg::ACT_POINT, p, c, 16'($urandom), 1'b0);
    for (int i = 0; i < PreN; i++)
      for (int j = i + 1; j < PreN; j++)
        send(dths_pkg::ACT_SIM, i, j, 16'($urandom), 1'($urandom));

    // Directed: saturating tanh from full-scale coordinates and weights.
    set_shape(4, 5, 5);
    send(dths_pkg::ACT_POINT, 0, 0, 16'h7FFF, 1'b0);
    send(dths_pkg::ACT_POINT, 0, 4, 16'h8000, 1'b0);
    send(dths_pkg::ACT_WEIGHT, 0, 0, 16'h7FFF, 1'b0);
    send(dths_pkg::ACT_WEIGHT, 4, 4, 16'h8000, 1'b0);
    send(dths_pkg::ACT_WEIGHT, 4, 5, 16'h8000, 1'b0);
    send(dths_pkg::ACT_WEIGHT, 0, 5, 16'h0000, 1'b0);
    send(dths_pkg::ACT_SIM, 0, 1, 16'h0, 1'b1);
    send(dths_pkg::ACT_SIM, 2, 3, 16'hFFFF, 1'b0);
    // Out-of-range loads are dropped by the block.
    send(dths_pkg::ACT_WEIGHT, 5, 0, 16'h1234, 1'b0);
    send(dths_pkg::ACT_WEIGHT, 127, 127, 16'h1234, 1'b0);
    send(dths_pkg::ACT_WEIGHT, 0, 6, 16'h1234, 1'b0);
    send(dths_pkg::ACT_POINT, 127, 5, 16'h1234, 1'b0);
    send(dths_pkg::ACT_POINT, 3, 127, 16'h1234, 1'b1);
    send(dths_pkg::ACT_RUN, 127, 127, 16'hFFFF, 1'b1);
    // Bias only, and widths above the maximum.
    set_shape(3, 0, 1);
    send(dths_pkg::ACT_RUN, 0, 0, 16'h0, 1'b0);
    set_shape(5, 7, 7);
    send(dths_pkg::ACT_RUN, 0, 0, 16'h0, 1'b0);
    // Zero outputs: every distance ties, the first pair wins.
    set_shape(4, 2, 0);
    send(dths_pkg::ACT_RUN, 0, 0, 16'h0, 1'b0);
    // Too few points: pairs stay as they were.
    set_shape(0, 2, 2);
    send(dths_pkg::ACT_RUN, 0, 0, 16'h0, 1'b0);
    set_shape(1, 2, 2);
    send(dths_pkg::ACT_RUN, 0, 0, 16'h0, 1'b0);

    // Random phases: mostly loads into the active region, then a run.
    for (int phase = 0; phase < 8; phase++) begin
      n = $urandom_range(2, PreN);
      set_shape(n, $urandom_range(0, 7), $urandom_range(0, 7));
      idle_odds = (phase % 3 == 2) ? 0 : $urandom_range(5, 60);
      if (phase == 7) quiet = 1;
      for (int k = 0; k < 28; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send(dths_pkg::ACT_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
               16'($urandom), 1'($urandom));
        end else if (pick < 15) begin
          // Full-range indices; weight and point loads are mostly dropped.
          send(2'($urandom), $urandom_range(0, 127), $urandom_range(0, 127),
               16'($urandom), 1'($urandom));
        end else if (pick < 40) begin
          send(dths_pkg::ACT_WEIGHT, $urandom_range(0, 5), $urandom_range(0, 6),
               16'($urandom), 1'b0);
        end else if (pick < 70) begin
          send(dths_pkg::ACT_POINT, $urandom_range(0, n + 2), $urandom_range(0, 5),
               16'($urandom), 1'b0);
        end else begin
          send(dths_pkg::ACT_SIM, $urandom_range(0, n), $urandom_range(0, n),
               16'($urandom), 1'($urandom));
        end
      end
      send(dths_pkg::ACT_RUN, 0, 0, 16'h0, 1'b0);
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: dense_tanh_hard_pair_search.f
hw/rtl/dths_pkg.sv
hw/rtl/dths_ram.sv
hw/rtl/dths_isqrt.sv
hw/rtl/dths_core.sv
hw/rtl/dense_tanh_hard_pair_search.sv
tb/sv/dense_tanh_hard_pair_search_checker.sv
tb/sv/dense_tanh_hard_pair_search_test.sv
